// ===== src/rmf_pkg.sv =====
// Shared types and constants of the RGB 3x3 median filter.
package rmf_pkg;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned FW_BITS      = 11;
  localparam int unsigned FH_BITS      = 16;
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;

  // Column queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned LEVEL_W    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // Per-column control that travels with each queued column.
  typedef struct packed {
    logic emit;    // this step produces an output pixel
    logic rclamp;  // right neighbor column is replicated from the center
    logic lclamp;  // left neighbor column is replicated from the center
    logic last;    // output pixel is the last of the frame
  } col_ctl_t;

endpackage

// ===== src/rmf_front.sv =====
// Front end: position counters, the two line memories and column assembly.
module rmf_front #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  rmf_pkg::cfg_idx_e                 cfg_index_i,
  input  logic [rmf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [3*CHANNEL_BITS-1:0]         pix_i,
  input  logic [rmf_pkg::LEVEL_W-1:0]       fifo_level_i,
  output logic                              push_o,
  output logic [9*CHANNEL_BITS-1:0]         col_o,
  output rmf_pkg::col_ctl_t                 ctl_o
);
  import rmf_pkg::*;

  localparam int unsigned PW = 3 * CHANNEL_BITS;
  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW = FH_BITS + 1;

  logic [FW_BITS-1:0] fw_q;
  logic [FH_BITS-1:0] fh_q;
  logic [WW-1:0]      w_eff;
  logic [YW-1:0]      h_eff;
  logic [XW-1:0]      x_q;
  logic [YW-1:0]      y_q;
  logic               acc, live, tick, store, x_is0, x_end;
  col_ctl_t           ctl_d;

  logic [PW-1:0] line0_mem [MAX_WIDTH];
  logic [PW-1:0] line1_mem [MAX_WIDTH];
  logic [PW-1:0] rd0_q, rd1_q;

  logic          s1_valid_q;
  logic [PW-1:0] s1_pix_q;
  logic          s1_par_q, s1_topc_q, s1_botc_q;
  col_ctl_t      s1_ctl_q;
  logic [PW-1:0] top, mid, bot;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
  end

  assign h_eff = (fh_q == '0) ? YW'(1) : {1'b0, fh_q};

  assign in_ready_o = (32'(fifo_level_i) + 32'(s1_valid_q)) < FIFO_DEPTH;
  assign acc   = in_valid_i && in_ready_o;
  assign live  = y_q < h_eff;
  // A flush before the last pixel is taken but leaves no trace.
  assign tick  = acc && !(live && mode_i);
  assign store = tick && live;
  assign x_is0 = (x_q == '0);
  assign x_end = 32'(x_q) == (32'(w_eff) - 32'd1);

  always_comb begin
    ctl_d.emit   = (y_q >= YW'(2)) || ((y_q == YW'(1)) && !x_is0);
    ctl_d.rclamp = x_is0;
    ctl_d.lclamp = x_is0 ? (w_eff == WW'(1)) : (x_q == XW'(1));
    ctl_d.last   = x_is0 && (y_q == h_eff + YW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= FW_BITS'(WIDTH_RESET);
      fh_q       <= FH_BITS'(HEIGHT_RESET);
      x_q        <= '0;
      y_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= tick;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_BITS-1:0];
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_BITS-1:0];
          default: ;
        endcase
        x_q <= '0;
        y_q <= '0;
      end else if (tick) begin
        if (ctl_d.last) begin
          x_q <= '0;
          y_q <= '0;
        end else if (x_end) begin
          x_q <= '0;
          y_q <= y_q + YW'(1);
        end else begin
          x_q <= x_q + XW'(1);
        end
      end
    end
  end

  // Even rows go to line0, odd rows to line1; both are read at the column.
  always_ff @(posedge clk_i) begin
    if (store && !y_q[0]) begin
      line0_mem[x_q] <= pix_i;
    end
    if (acc) begin
      rd0_q <= line0_mem[x_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (store && y_q[0]) begin
      line1_mem[x_q] <= pix_i;
    end
    if (acc) begin
      rd1_q <= line1_mem[x_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      s1_pix_q  <= pix_i;
      s1_par_q  <= y_q[0];
      s1_topc_q <= (y_q == YW'(1));
      s1_botc_q <= !live;
      s1_ctl_q  <= ctl_d;
    end
  end

  // Column centered on the previous row, with top and bottom edge replication.
  assign mid = s1_par_q ? rd0_q : rd1_q;
  assign top = s1_topc_q ? mid : (s1_par_q ? rd1_q : rd0_q);
  assign bot = s1_botc_q ? mid : s1_pix_q;

  assign push_o = s1_valid_q;
  assign col_o  = {bot, mid, top};
  assign ctl_o  = s1_ctl_q;

`ifndef SYNTHESIS
  a_flush_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && live && mode_i && !cfg_valid_i) |=> !push_o)
    else $error("ignored flush produced a column");
`endif

endmodule

// ===== src/rmf_fifo.sv =====
// Short column queue between the front end and the median back end.
module rmf_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [DW-1:0]               data_i,
  input  logic                        pop_i,
  output logic [DW-1:0]               data_o,
  output logic                        valid_o,
  output logic [rmf_pkg::LEVEL_W-1:0] level_o
);
  import rmf_pkg::*;

  logic [DW-1:0]      mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [LEVEL_W-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + LEVEL_W'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign valid_o = (level_q != '0);
  assign level_o = level_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ((32'(level_q) < FIFO_DEPTH) || pop_i))
    else $error("column queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (level_q != '0))
    else $error("column queue underflow");
`endif

endmodule

// ===== src/rmf_back.sv =====
// Back end: 3x3 window of columns and the pipelined per-channel median.
module rmf_back #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fifo_valid_i,
  input  logic [9*CHANNEL_BITS-1:0] col_i,
  input  rmf_pkg::col_ctl_t         ctl_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CHANNEL_BITS-1:0]   red_o,
  output logic [CHANNEL_BITS-1:0]   green_o,
  output logic [CHANNEL_BITS-1:0]   blue_o,
  output logic                      frame_end_o
);
  import rmf_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;

  function automatic logic [CB-1:0] min2(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [CB-1:0] max2(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [CB-1:0] med3(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                         input logic [CB-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic          en;
  logic [CB-1:0] n_px [3][3];   // row, channel
  logic [CB-1:0] p1_q [3][3];
  logic [CB-1:0] p2_q [3][3];
  logic [CB-1:0] win_q [3][3][3];  // column, row, channel
  logic [CB-1:0] sb_q [3][3][3];   // channel, column, rank
  logic [CB-1:0] sc_q [3][3];      // channel, rank
  logic [CB-1:0] out_q [3];
  logic          wv_q, bv_q, cv_q, out_valid_q;
  logic          wl_q, bl_q, cl_q, ol_q;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && fifo_valid_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int ch = 0; ch < 3; ch++) begin
        n_px[r][ch] = col_i[(r*3+ch)*CB +: CB];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q        <= 1'b0;
      bv_q        <= 1'b0;
      cv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      wv_q        <= pop_o && ctl_i.emit;
      bv_q        <= wv_q;
      cv_q        <= bv_q;
      out_valid_q <= cv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int r = 0; r < 3; r++) begin
        for (int ch = 0; ch < 3; ch++) begin
          p2_q[r][ch]     <= p1_q[r][ch];
          p1_q[r][ch]     <= n_px[r][ch];
          win_q[0][r][ch] <= ctl_i.lclamp ? p1_q[r][ch] : p2_q[r][ch];
          win_q[1][r][ch] <= p1_q[r][ch];
          win_q[2][r][ch] <= ctl_i.rclamp ? p1_q[r][ch] : n_px[r][ch];
        end
      end
      wl_q <= ctl_i.last;
    end
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int c = 0; c < 3; c++) begin
          sb_q[ch][c][0] <= min2(min2(win_q[c][0][ch], win_q[c][1][ch]), win_q[c][2][ch]);
          sb_q[ch][c][1] <= med3(win_q[c][0][ch], win_q[c][1][ch], win_q[c][2][ch]);
          sb_q[ch][c][2] <= max2(max2(win_q[c][0][ch], win_q[c][1][ch]), win_q[c][2][ch]);
        end
        sc_q[ch][0] <= max2(max2(sb_q[ch][0][0], sb_q[ch][1][0]), sb_q[ch][2][0]);
        sc_q[ch][1] <= med3(sb_q[ch][0][1], sb_q[ch][1][1], sb_q[ch][2][1]);
        sc_q[ch][2] <= min2(min2(sb_q[ch][0][2], sb_q[ch][1][2]), sb_q[ch][2][2]);
        out_q[ch]   <= med3(sc_q[ch][0], sc_q[ch][1], sc_q[ch][2]);
      end
      bl_q <= wl_q;
      cl_q <= bl_q;
      ol_q <= cl_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];
  assign frame_end_o = ol_q;

endmodule

// ===== src/rgb_median3x3_filter.sv =====
// Top level of the streaming RGB 3x3 per-channel median filter.
//
// Pixels enter in raster order on the input channel (in_valid_i/in_ready_o),
// one transfer per pixel with mode_i low. For each pixel the block returns,
// in raster order, the median of each color channel over its 3x3
// neighborhood, with neighbors outside the frame replaced by the nearest edge
// pixel. Output k becomes due with input transfer k+width+1; after the last
// pixel of a frame the source sends width+1 flush transfers (mode_i high) to
// drain the frame. A flush sent before the last pixel is absorbed without
// effect, and a pixel sent during the drain acts as a flush. frame_end_o marks
// the last output pixel of a frame, after which the next pixel opens a new one.
// Throughput is one transfer per clock while the receiver keeps up. A result
// travels from its triggering transfer through the line memory read register,
// the column queue, the window register and three compare stages.
// When the receiver stalls, the four-entry column queue absorbs the pipeline
// and then in_ready_o drops. Reset restores 640x480 and clears all positions;
// the line memories are not cleared. A configuration write also restarts the
// frame. The user must write only while the block is idle; the block does not check.
module rgb_median3x3_filter #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  rmf_pkg::cfg_idx_e              cfg_index_i,
  input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [CHANNEL_BITS-1:0]        red_in_i,
  input  logic [CHANNEL_BITS-1:0]        green_in_i,
  input  logic [CHANNEL_BITS-1:0]        blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [CHANNEL_BITS-1:0]        red_out_o,
  output logic [CHANNEL_BITS-1:0]        green_out_o,
  output logic [CHANNEL_BITS-1:0]        blue_out_o,
  output logic                           frame_end_o
);
  import rmf_pkg::*;

  localparam int unsigned COL_W = 9 * CHANNEL_BITS;
  localparam int unsigned Q_W   = COL_W + $bits(col_ctl_t);

  logic               push, pop, q_valid;
  logic [COL_W-1:0]   push_col;
  col_ctl_t           push_ctl, pop_ctl;
  logic [Q_W-1:0]     q_out;
  logic [LEVEL_W-1:0] q_level;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  rmf_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .pix_i        ({blue_in_i, green_in_i, red_in_i}),
    .fifo_level_i (q_level),
    .push_o       (push),
    .col_o        (push_col),
    .ctl_o        (push_ctl)
  );

  rmf_fifo #(
    .DW (Q_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_ctl, push_col}),
    .pop_i   (pop),
    .data_o  (q_out),
    .valid_o (q_valid),
    .level_o (q_level)
  );

  assign pop_ctl = q_out[Q_W-1:COL_W];

  rmf_back #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (q_valid),
    .col_i        (q_out[COL_W-1:0]),
    .ctl_i        (pop_ctl),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_out_o),
    .green_o      (green_out_o),
    .blue_o       (blue_out_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the RGB 3x3 median filter, with a built-in predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmf_pkg::*;

  localparam int unsigned MAX_W     = 1024;
  localparam int unsigned HIST_LEN  = 2 * MAX_W + 9;
  localparam int unsigned RUN_ITEMS = 1800;
  localparam int unsigned LIMIT     = 3_000_000;
  localparam int unsigned SETTLE    = 16;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } pix_t;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        fe;
  } med_t;

  typedef struct packed {
    logic        mode;
    pix_t        px;
    logic        typed;
    med_t        want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_e    cfg_index = CFG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [15:0] red_in = '0, green_in = '0, blue_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] red_out, green_out, blue_out;
  logic        frame_end;

  rgb_median3x3_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .red_out_o   (red_out),
    .green_out_o (green_out),
    .blue_out_o  (blue_out),
    .frame_end_o (frame_end)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: the register copies, the pixel history ring and the
  // four raster positions of the block.
  logic [10:0]  pr_width = 11'd640;
  logic [15:0]  pr_height = 16'd480;
  pix_t         pixel_hist [HIST_LEN];
  int unsigned  in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  med_t         medians_due [$];
  int           errors = 0;
  int unsigned  cycles = 0;
  int unsigned  items_sent = 0;
  int unsigned  ready_pct = 100;
  bit           no_gaps = 1'b0;
  dir_row_t     dir_rows [15];

  function automatic logic [15:0] median_of9(logic [15:0] v [9]);
    logic [15:0] key;
    int          j;
    for (int i = 1; i < 9; i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    return v[4];
  endfunction

  function automatic int clamp_pos(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Advances the predictor by one accepted transfer. Returns 1 when the
  // transfer releases an output pixel, which is then left in med.
  function automatic bit predict_median(logic md, pix_t px, output med_t med);
    int unsigned w, h, ring, total, tick, pos;
    int          nx, ny;
    logic [15:0] rv [9], gv [9], bv [9];
    bit          got, last;
    got = 1'b0;
    med = '0;
    w = (pr_width == 0) ? 1 : ((pr_width > MAX_W) ? MAX_W : pr_width);
    h = (pr_height == 0) ? 1 : pr_height;
    ring = 2 * w + 3;
    total = w * h;
    tick = in_row * w + in_col;
    if (tick < total) begin
      // A flush before the last pixel is swallowed without any effect.
      if (md) return 1'b0;
      pixel_hist[tick % ring] = px;
    end
    if (tick >= w + 1) begin
      for (int i = 0; i < 9; i++) begin
        nx = clamp_pos(int'(out_col) + (i % 3) - 1, int'(w) - 1);
        ny = clamp_pos(int'(out_row) + (i / 3) - 1, int'(h) - 1);
        pos = ny * w + nx;
        rv[i] = pixel_hist[pos % ring].r;
        gv[i] = pixel_hist[pos % ring].g;
        bv[i] = pixel_hist[pos % ring].b;
      end
      last = (out_row == h - 1) && (out_col == w - 1);
      med.r = median_of9(rv);
      med.g = median_of9(gv);
      med.b = median_of9(bv);
      med.fe = last;
      if (last) begin
        restart_frame();
        return 1'b1;
      end
      got = 1'b1;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    return got;
  endfunction

  // Most gaps are short, a few are long, and some frames run with none.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_chan();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drives one input transfer and books its expected output. A typed
  // expectation replaces the predicted one where it is given.
  task automatic send_item(logic md, pix_t px, bit typed, med_t want);
    int unsigned gap;
    med_t        pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode     <= md;
    red_in   <= px.r;
    green_in <= px.g;
    blue_in  <= px.b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    if (predict_median(md, px, pred)) medians_due.push_back(typed ? want : pred);
  endtask

  task automatic send_random(logic md);
    send_item(md, '{pick_chan(), pick_chan(), pick_chan()}, 1'b0, '0);
  endtask

  // Lets every due output drain, then waits out the pipeline so that a
  // drain tick still in flight cannot overlap a register write.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (medians_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx == CFG_FRAME_WIDTH) pr_width = data[10:0];
    else pr_height = data;
    restart_frame();
  endtask

  // One frame with random content. Noise flushes land among the pixels, the
  // drain mixes flush ticks with ignored pixels, and some frames are cut
  // short and abandoned by the next register write.
  task automatic run_frame(int unsigned w, int unsigned h, bit hold_mid);
    int unsigned npix, cut;
    npix = w * h;
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npix) : npix;
    for (int unsigned k = 0; k < cut; k++) begin
      if ($urandom_range(0, 9) == 0) send_random(1'b1);
      send_random(1'b0);
      if (hold_mid && k == npix / 2) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (medians_due.size() != 0) @(posedge clk_i);
      end
    end
    if (cut == npix) begin
      for (int unsigned k = 0; k <= w; k++) begin
        send_random(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic configure(logic [15:0] wdata, logic [15:0] hdata);
    wait_quiet();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_FRAME_WIDTH, wdata);
      write_reg(CFG_FRAME_HEIGHT, hdata);
    end else begin
      write_reg(CFG_FRAME_HEIGHT, hdata);
      write_reg(CFG_FRAME_WIDTH, wdata);
    end
    cfg_valid <= 1'b0;
    no_gaps = ($urandom_range(0, 4) == 0);
    ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(30, 90);
  endtask

  // Receiver: random stalls, now and then a long one.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(20, 60);
    end else begin
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Each output transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    med_t exp_med;
    if (rst_ni && out_valid && out_ready) begin
      if (medians_due.size() == 0) begin
        $error("output transfer with nothing expected");
        errors++;
      end else begin
        exp_med = medians_due.pop_front();
        if (red_out !== exp_med.r) begin
          $error("red_out expected %h got %h", exp_med.r, red_out);
          errors++;
        end
        if (green_out !== exp_med.g) begin
          $error("green_out expected %h got %h", exp_med.g, green_out);
          errors++;
        end
        if (blue_out !== exp_med.b) begin
          $error("blue_out expected %h got %h", exp_med.b, blue_out);
          errors++;
        end
        if (frame_end !== exp_med.fe) begin
          $error("frame_end expected %b got %b", exp_med.fe, frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("rgb_median3x3_filter regression: fail");
      $finish;
    end
  end

  initial begin
    // Directed frames on a 2x2 picture. The first frame is uniform white, so
    // every median is white; a leading flush is swallowed and a pixel sent
    // during the drain counts as a flush tick. The second mixes extremes.
    dir_rows[0]  = '{1'b1, '{16'h1234, 16'h5678, 16'h9ABC}, 1'b0, '0};
    dir_rows[1]  = '{1'b0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0};
    dir_rows[2]  = '{1'b0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0};
    dir_rows[3]  = '{1'b0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0};
    dir_rows[4]  = '{1'b0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}};
    dir_rows[5]  = '{1'b1, '{16'h0000, 16'h0000, 16'h0000}, 1'b1,
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}};
    dir_rows[6]  = '{1'b0, '{16'h0000, 16'h0000, 16'h0000}, 1'b1,
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}};
    dir_rows[7]  = '{1'b1, '{16'h0000, 16'h0000, 16'h0000}, 1'b1,
                     '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}};
    dir_rows[8]  = '{1'b0, '{16'h0000, 16'hFFFF, 16'h8000}, 1'b0, '0};
    dir_rows[9]  = '{1'b0, '{16'hFFFF, 16'h0000, 16'h0001}, 1'b0, '0};
    dir_rows[10] = '{1'b0, '{16'h7FFF, 16'hFFFF, 16'h0000}, 1'b0, '0};
    dir_rows[11] = '{1'b0, '{16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0};
    dir_rows[12] = '{1'b1, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0};
    dir_rows[13] = '{1'b1, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0};
    dir_rows[14] = '{1'b1, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry with 640-pixel lines: a run just past the first line
    // plus one shows that outputs start there. The frame is abandoned.
    for (int k = 0; k < 643; k++) send_random(1'b0);

    configure(16'd2, 16'd2);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].mode, dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
    end

    // Register extremes: width zero acts as one, height zero acts as one,
    // width above the line store acts as full width, upper data bits of
    // the width write are dropped, and a tall frame is abandoned early.
    configure(16'd0, 16'd5);
    run_frame(1, 5, 1'b1);
    configure(16'd3, 16'd0);
    run_frame(3, 1, 1'b0);
    configure(16'd1, 16'd1);
    run_frame(1, 1, 1'b0);
    configure(16'hF803, 16'd3);
    run_frame(3, 3, 1'b0);
    configure(16'd2047, 16'd1);
    for (int k = 0; k < MAX_W + 3; k++) send_random(1'b0);
    configure(16'd4, 16'hFFFF);
    for (int k = 0; k < 24; k++) send_random(1'b0);

    // Random frames, mostly small, a few wider.
    while (items_sent < RUN_ITEMS) begin
      automatic int unsigned w = ($urandom_range(0, 9) == 0) ?
                                 $urandom_range(13, 40) : $urandom_range(1, 12);
      automatic int unsigned h = $urandom_range(1, 6);
      configure(16'(w), 16'(h));
      run_frame(w, h, 1'b0);
    end

    wait_quiet();
    if (errors == 0) begin
      $display("rgb_median3x3_filter regression: pass");
    end else begin
      $display("rgb_median3x3_filter regression: fail");
    end
    $finish;
  end

endmodule
